FILE: hdl/orbit_camera_position_defines.svh
// assertion macros for the orbit camera block
// expects clk and rst in the scope of the module that uses them
`ifndef ORBIT_CAMERA_POSITION_DEFINES_SVH
`define ORBIT_CAMERA_POSITION_DEFINES_SVH

// same-cycle implication, disabled during reset
`define OCP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define OCP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/ocp_pkg.sv
// shared types, constants and helper functions for the orbit camera block
// no dependencies; imported by every module of the block
`default_nettype none

package ocp_pkg;

  // trig table size and derived index width
  localparam int SINE_TABLE_ENTRIES = 256;
  localparam int IDXW = $clog2(SINE_TABLE_ENTRIES);

  // angles in degrees q9.7
  localparam logic [15:0] TURN    = 16'd46080;
  localparam logic [15:0] QUARTER = 16'd11520;
  localparam logic [13:0] PITCH_LO = 14'd128;
  localparam logic [13:0] PITCH_HI = 14'd11392;
  // 46080 * 2^15, keeps the orbit sum positive without changing its residue
  localparam logic [31:0] ORBIT_BIAS = 32'd1509949440;

  // reset values
  localparam logic [15:0] SPEED_GAIN_RESET = 16'd26;
  localparam logic [30:0] MIN_DIST_RESET   = 31'd655360;
  localparam logic [30:0] MAX_DIST_RESET   = 31'd6553600;
  localparam logic [30:0] ZOOM_RESET       = 31'd3276800;
  localparam logic [13:0] PITCH_RESET      = 14'd2560;

  // serial divider by a full turn
  localparam int CNTW = 5;
  localparam int MOD_STEPS = 17;
  localparam int NUMW = 16 + IDXW;

  // serial multiplier
  localparam int MUL_STEPS = 16;
  localparam int MULCW = $clog2(MUL_STEPS);

  // saturation bounds
  localparam logic signed [34:0] SAT_MAX = 35'sd2147483647;
  localparam logic signed [34:0] SAT_MIN = -35'sd2147483648;

  // q30 constants for the table build
  localparam longint unsigned Q30_ONE     = 64'd1073741824;
  localparam longint unsigned Q30_PI      = 64'd3373259426;
  localparam longint unsigned Q30_HALF_PI = 64'd1686629713;
  localparam longint unsigned Q30_TWO_PI  = 64'd6746518852;

  typedef enum logic [1:0] {
    REG_SPEED_GAIN = 2'd0,
    REG_ZOOM_MIN   = 2'd1,
    REG_ZOOM_MAX   = 2'd2
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PROD,
    S_UPD,
    S_DIV1_GO,
    S_DIV1_WAIT,
    S_DIV2_GO,
    S_DIV2_WAIT,
    S_DIV3_GO,
    S_DIV3_WAIT,
    S_MUL_GO,
    S_MUL_WAIT
  } state_t;

  typedef struct packed {
    logic               scroll_valid;
    logic signed [7:0]  scroll_steps;
    logic               right_button;
    logic               left_button;
    logic signed [15:0] mouse_dx;
    logic signed [15:0] mouse_dy;
    logic signed [31:0] player_x;
    logic signed [31:0] player_y;
    logic signed [31:0] player_z;
    logic [15:0]        player_heading;
  } ocp_in_t;

  typedef struct packed {
    logic signed [31:0] cam_x;
    logic signed [31:0] cam_y;
    logic signed [31:0] cam_z;
    logic [13:0]        pitch_deg;
  } ocp_out_t;

  // start values for a long division by a full turn, bits fed msb first
  typedef struct packed {
    logic [15:0]     r0;
    logic [31:0]     bits;
    logic [CNTW-1:0] count;
  } div_req_t;

  typedef logic signed [15:0] sine_tab_t [SINE_TABLE_ENTRIES];

  function automatic logic signed [15:0] sine_entry(input longint unsigned i);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    logic neg;
    x = (i * Q30_TWO_PI + SINE_TABLE_ENTRIES / 2) / SINE_TABLE_ENTRIES;
    neg = 1'b0;
    if (x >= Q30_TWO_PI) x = x - Q30_TWO_PI;
    if (x > Q30_PI) begin
      x = x - Q30_PI;
      neg = 1'b1;
    end
    if (x > Q30_HALF_PI) x = Q30_PI - x;
    x2 = (x * x) >> 30;
    t = Q30_ONE - x2 / 72;
    t = Q30_ONE - ((x2 * t) >> 30) / 42;
    t = Q30_ONE - ((x2 * t) >> 30) / 20;
    t = Q30_ONE - ((x2 * t) >> 30) / 6;
    s = (x * t) >> 30;
    s = (s + 64'd16384) >> 15;
    if (s > 64'd32767) s = 64'd32767;
    return neg ? -16'(s) : 16'(s);
  endfunction

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t tab;
    for (int i = 0; i < SINE_TABLE_ENTRIES; i++) begin
      tab[i] = sine_entry(64'(i));
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

  // reduce a 32-bit value mod a full turn: top bits preload, rest shifted in
  function automatic div_req_t mod_req(input logic [31:0] v);
    div_req_t r;
    r.r0    = 16'(v >> MOD_STEPS);
    r.bits  = v << (32 - MOD_STEPS);
    r.count = CNTW'(MOD_STEPS);
    return r;
  endfunction

  // table index floor(a*N/46080), an IDXW-bit quotient
  function automatic div_req_t idx_req(input logic [15:0] a);
    div_req_t r;
    logic [NUMW-1:0] num;
    num     = NUMW'(a) * NUMW'(SINE_TABLE_ENTRIES);
    r.r0    = 16'(num >> IDXW);
    r.bits  = {num[IDXW-1:0], {(32 - IDXW){1'b0}}};
    r.count = CNTW'(IDXW);
    return r;
  endfunction

  // floor((p + 2^14) / 2^15)
  function automatic logic signed [32:0] rnd_q15(input logic signed [47:0] p);
    logic signed [47:0] q;
    q = p + 48'sd16384;
    return q[47:15];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) r = 32'h7fffffff;
    else if (v < SAT_MIN) r = 32'h80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/ocp_turn_div.sv
// bit-serial long division by a full turn (46080), one numerator bit a cycle
// depends on ocp_pkg
`default_nettype none

module ocp_turn_div
  import ocp_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire div_req_t        req,
  output logic                 busy,
  output logic [15:0]          rem,
  output logic [IDXW-1:0]      quo
);

  logic [CNTW-1:0] cnt;
  logic [31:0]     bits;
  logic [16:0]     trial;
  logic            ge;
  logic [15:0]     rem_next;

  always_comb begin
    trial = {rem, bits[31]};
    ge = trial >= {1'b0, TURN};
    rem_next = ge ? 16'(trial - {1'b0, TURN}) : trial[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == CNTW'(1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt  <= req.count;
      rem  <= req.r0;
      bits <= req.bits;
    end else if (busy) begin
      cnt  <= cnt - CNTW'(1);
      rem  <= rem_next;
      bits <= bits << 1;
      quo  <= {quo[IDXW-2:0], ge};
    end
  end

endmodule

`default_nettype wire

FILE: hdl/ocp_mul_serial.sv
// shift-add multiplier, signed 32 x signed 16, one multiplier bit a cycle
// depends on ocp_pkg
`default_nettype none

module ocp_mul_serial
  import ocp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [31:0] a,
  input  wire logic signed [15:0] b,
  output logic                    busy,
  output logic signed [47:0]      p
);

  logic [MULCW-1:0]   cnt;
  logic signed [47:0] mc;
  logic [15:0]        mb;
  logic               last;
  logic signed [47:0] addend;

  always_comb begin
    last = cnt == MULCW'(MUL_STEPS - 1);
    addend = mb[0] ? mc : 48'sd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= '0;
      p   <= '0;
      mc  <= 48'(a);
      mb  <= b;
    end else if (busy) begin
      cnt <= cnt + MULCW'(1);
      // sign bit of b carries negative weight
      p   <= last ? p - addend : p + addend;
      mc  <= mc <<< 1;
      mb  <= mb >> 1;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/orbit_camera_position.sv
// orbit camera: the mod-360 reduction (17 serial steps) and sin(pitch) index run together,
// then the cos(pitch) and sin(theta) indexes, then two rounds of 16-step serial multiplies
// with the cos(theta) index beside the first; the next item is taken the cycle after the
// result is loaded, which waits only if the previous result is still held
// synchronous reset restores the control and config registers, zoom 50.0, pitch 20 deg and orbit 0
// depends on ocp_pkg, ocp_turn_div, ocp_mul_serial, orbit_camera_position_defines.svh
`default_nettype none
`include "orbit_camera_position_defines.svh"

module orbit_camera_position
  import ocp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        tick_valid,
  output logic             tick_ready,
  input  wire ocp_in_t     tick,
  output logic             cam_valid,
  input  wire logic        cam_ready,
  output ocp_out_t         cam,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [30:0] cfg_data
);

  state_t state, state_next;

  logic [15:0] speed_gain;
  logic [30:0] zoom_min;
  logic [30:0] zoom_max;

  logic [30:0] zoom, zoom_next;
  logic [13:0] pitch, pitch_next;
  logic [15:0] orbit;

  ocp_in_t            tick_r;
  logic signed [24:0] zg;
  logic signed [32:0] pg;
  logic signed [32:0] og;
  logic [31:0]        orbit_num, orbit_num_next;
  logic [15:0]        hw, hw_next;
  logic [15:0]        theta_w, theta_c, theta_c_next;
  logic signed [15:0] sp, cp, st, ct;
  logic signed [31:0] hd, vd;

  logic signed [33:0] zsum, zclamp, psum, pclamp, osum;
  logic [16:0]        theta_sum, theta_c_sum;
  logic signed [32:0] hx, hz, hd_full, vd_full;

  logic        div_a_start, div_b_start, div_a_busy, div_b_busy;
  div_req_t    div_a_req, div_b_req;
  logic [15:0] div_a_rem, div_b_rem;
  logic [IDXW-1:0] div_a_quo, div_b_quo;

  logic               mul_a_start, mul_b_start, mul_a_busy, mul_b_busy;
  logic signed [31:0] mul_a_a, mul_b_a;
  logic signed [15:0] mul_a_b, mul_b_b;
  logic signed [47:0] mul_a_p, mul_b_p;

  logic tick_take, out_free, divs_idle, muls_idle;

  ocp_turn_div u_div_a (
    .clk(clk), .rst(rst), .start(div_a_start), .req(div_a_req),
    .busy(div_a_busy), .rem(div_a_rem), .quo(div_a_quo)
  );

  ocp_turn_div u_div_b (
    .clk(clk), .rst(rst), .start(div_b_start), .req(div_b_req),
    .busy(div_b_busy), .rem(div_b_rem), .quo(div_b_quo)
  );

  ocp_mul_serial u_mul_a (
    .clk(clk), .rst(rst), .start(mul_a_start), .a(mul_a_a), .b(mul_a_b),
    .busy(mul_a_busy), .p(mul_a_p)
  );

  ocp_mul_serial u_mul_b (
    .clk(clk), .rst(rst), .start(mul_b_start), .a(mul_b_a), .b(mul_b_b),
    .busy(mul_b_busy), .p(mul_b_p)
  );

  assign tick_ready = state == S_IDLE;
  assign tick_take  = tick_valid && tick_ready;
  assign out_free   = !cam_valid || cam_ready;
  assign divs_idle  = !div_a_busy && !div_b_busy;
  assign muls_idle  = !mul_a_busy && !mul_b_busy;

  // per-tick state update
  always_comb begin
    zsum = $signed({3'b0, zoom}) - $signed({zg[24], zg, 8'b0});
    zclamp = zsum;
    if (zclamp < $signed({3'b0, zoom_min})) zclamp = $signed({3'b0, zoom_min});
    if (zclamp > $signed({3'b0, zoom_max})) zclamp = $signed({3'b0, zoom_max});
    zoom_next = tick_r.scroll_valid ? zclamp[30:0] : zoom;

    psum = $signed({20'b0, pitch})
         - (tick_r.right_button ? $signed({pg[32], pg[32], pg[32:1]}) : 34'sd0);
    pclamp = psum;
    if (pclamp < $signed({20'b0, PITCH_LO})) pclamp = $signed({20'b0, PITCH_LO});
    if (pclamp > $signed({20'b0, PITCH_HI})) pclamp = $signed({20'b0, PITCH_HI});
    pitch_next = pclamp[13:0];

    osum = $signed({18'b0, orbit})
         - (tick_r.left_button ? $signed({og[32], og[32], og[32:1]}) : 34'sd0)
         + $signed({2'b0, ORBIT_BIAS});
    orbit_num_next = osum[31:0];

    hw_next = (tick_r.player_heading >= TURN) ? tick_r.player_heading - TURN
                                              : tick_r.player_heading;

    theta_sum = {1'b0, hw} + {1'b0, orbit};
    theta_w = (theta_sum >= {1'b0, TURN}) ? 16'(theta_sum - {1'b0, TURN})
                                          : theta_sum[15:0];
    theta_c_sum = {1'b0, theta_w} + {1'b0, QUARTER};
    theta_c_next = (theta_c_sum >= {1'b0, TURN}) ? 16'(theta_c_sum - {1'b0, TURN})
                                                 : theta_c_sum[15:0];

    hd_full = rnd_q15(mul_a_p);
    vd_full = rnd_q15(mul_b_p);
    hx = rnd_q15(mul_a_p);
    hz = rnd_q15(mul_b_p);
  end

  always_comb begin
    state_next  = state;
    div_a_start = 1'b0;
    div_b_start = 1'b0;
    div_a_req   = mod_req(orbit_num);
    div_b_req   = idx_req({2'b0, pitch});
    mul_a_start = 1'b0;
    mul_b_start = 1'b0;
    mul_a_a     = $signed({1'b0, zoom});
    mul_a_b     = cp;
    mul_b_a     = $signed({1'b0, zoom});
    mul_b_b     = sp;
    case (state)
      S_IDLE: begin
        if (tick_valid) state_next = S_PROD;
      end
      S_PROD: state_next = S_UPD;
      S_UPD: state_next = S_DIV1_GO;
      S_DIV1_GO: begin
        // orbit wrap and sin(pitch) index
        div_a_start = 1'b1;
        div_b_start = 1'b1;
        state_next  = S_DIV1_WAIT;
      end
      S_DIV1_WAIT: begin
        if (divs_idle) state_next = S_DIV2_GO;
      end
      S_DIV2_GO: begin
        // cos(pitch) and sin(theta) indexes
        div_a_req   = idx_req({2'b0, pitch} + QUARTER);
        div_b_req   = idx_req(theta_w);
        div_a_start = 1'b1;
        div_b_start = 1'b1;
        state_next  = S_DIV2_WAIT;
      end
      S_DIV2_WAIT: begin
        if (divs_idle) state_next = S_DIV3_GO;
      end
      S_DIV3_GO: begin
        // cos(theta) index alongside the distance split
        div_a_req   = idx_req(theta_c);
        div_a_start = 1'b1;
        mul_a_start = 1'b1;
        mul_b_start = 1'b1;
        state_next  = S_DIV3_WAIT;
      end
      S_DIV3_WAIT: begin
        if (!div_a_busy && muls_idle) state_next = S_MUL_GO;
      end
      S_MUL_GO: begin
        mul_a_a     = hd;
        mul_a_b     = st;
        mul_b_a     = hd;
        mul_b_b     = ct;
        mul_a_start = 1'b1;
        mul_b_start = 1'b1;
        state_next  = S_MUL_WAIT;
      end
      S_MUL_WAIT: begin
        if (muls_idle && out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control, configuration and persistent state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cam_valid  <= 1'b0;
      speed_gain <= SPEED_GAIN_RESET;
      zoom_min   <= MIN_DIST_RESET;
      zoom_max   <= MAX_DIST_RESET;
      zoom       <= ZOOM_RESET;
      pitch      <= PITCH_RESET;
      orbit      <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_SPEED_GAIN: speed_gain <= cfg_data[15:0];
          REG_ZOOM_MIN:   zoom_min   <= cfg_data;
          REG_ZOOM_MAX:   zoom_max   <= cfg_data;
          default: ;
        endcase
      end
      if (state == S_UPD) begin
        zoom  <= zoom_next;
        pitch <= pitch_next;
      end
      if (state == S_DIV1_WAIT && divs_idle) orbit <= div_a_rem;
      if (state == S_MUL_WAIT && muls_idle && out_free) begin
        cam_valid <= 1'b1;
      end else if (cam_ready) begin
        cam_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (tick_take) tick_r <= tick;
      end
      S_PROD: begin
        zg <= $signed(tick_r.scroll_steps) * $signed({1'b0, speed_gain});
        pg <= $signed(tick_r.mouse_dy) * $signed({1'b0, speed_gain});
        og <= $signed(tick_r.mouse_dx) * $signed({1'b0, speed_gain});
      end
      S_UPD: begin
        orbit_num <= orbit_num_next;
        hw        <= hw_next;
      end
      S_DIV1_WAIT: begin
        if (divs_idle) sp <= SINE_TAB[div_b_quo];
      end
      S_DIV2_GO: theta_c <= theta_c_next;
      S_DIV2_WAIT: begin
        if (divs_idle) begin
          cp <= SINE_TAB[div_a_quo];
          st <= SINE_TAB[div_b_quo];
        end
      end
      S_DIV3_WAIT: begin
        if (!div_a_busy && muls_idle) begin
          ct <= SINE_TAB[div_a_quo];
          hd <= hd_full[31:0];
          vd <= vd_full[31:0];
        end
      end
      S_MUL_WAIT: begin
        if (muls_idle && out_free) begin
          cam.cam_x     <= sat32($signed({{3{tick_r.player_x[31]}}, tick_r.player_x})
                                 - $signed({{2{hx[32]}}, hx}));
          cam.cam_y     <= sat32($signed({{3{tick_r.player_y[31]}}, tick_r.player_y})
                                 + $signed({{3{vd[31]}}, vd}));
          cam.cam_z     <= sat32($signed({{3{tick_r.player_z[31]}}, tick_r.player_z})
                                 - $signed({{2{hz[32]}}, hz}));
          cam.pitch_deg <= pitch;
        end
      end
      default: ;
    endcase
  end

  `OCP_ASSERT_IMP(a_pitch_range, 1'b1, pitch >= PITCH_LO && pitch <= PITCH_HI, "pitch out of range")
  `OCP_ASSERT_IMP(a_orbit_range, 1'b1, orbit < TURN, "orbit angle not wrapped")
  `OCP_ASSERT_IMP(a_div_rem, div_a_busy, div_a_rem < TURN, "divider remainder overflow")
  `OCP_ASSERT_NXT(a_take_starts, tick_valid && tick_ready, state == S_PROD && !div_a_busy && !mul_a_busy, "item taken while units busy")

endmodule

`default_nettype wire
